/* rtl/mcfir_pkg.sv */
package mcfir_pkg;

  // Field widths of the stream words
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int TAP_W    = 6;
  localparam int TCNT_W   = 7;
  localparam int CFG_IDX_W = 8;

  // Packed word widths (tdata padded to whole bytes)
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // Fraction bits dropped when going from Q3.45 back to Q1.23
  localparam int FRAC_SHIFT = 22;

  // Action codes
  localparam logic ACT_COEF   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 8'd1;

  // Saturation rails
  localparam logic [SAMPLE_W-1:0] SAT_MAX = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 24'h80_0000;

  // Reset value of the tap count
  localparam logic [TCNT_W-1:0] TAP_COUNT_RST = 7'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } fir_state_e;

endpackage

/* rtl/multichannel_fir_filter_with_bias.sv */
// A sample word is filtered over taps history entries of its channel, where taps is
// tap_count held to 1..MAX_TAPS.
// The single MAC walks the coefficient and history memories one tap per cycle;
// no new word is accepted until the result is loaded into the output register.
// A coefficient word is taken while idle and gives no result.
// Reset (async, active low) runs a clearing pass over all CHANNELS * MAX_TAPS history
// entries (128 at the defaults) that zeroes both memories; no word is accepted meanwhile.
module multichannel_fir_filter_with_bias #(
  parameter int MAX_TAPS = 64,
  parameter int CHANNELS = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcfir_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mcfir_pkg::SAMPLE_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tap_index[5:0], coefficient[29:6], sample[53:30], zero[55:54]
  input  logic [mcfir_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // action[0], channel[1]
  input  logic [mcfir_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // filtered[23:0]
  output logic [mcfir_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // out_channel[0], saturated[1]
  output logic [mcfir_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

  import mcfir_pkg::*;

  localparam int PW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HDEPTH = CHANNELS * MAX_TAPS;
  localparam int HW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int NW     = $clog2(MAX_TAPS + 1);
  localparam int CLRW   = $clog2(HDEPTH + 1);
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1) + 1;
  localparam int TOP_LO = FRAC_SHIFT + SAMPLE_W - 1;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  // Unpack input word
  logic                       in_action;
  logic                       in_channel;
  logic [TAP_W-1:0]           in_tap;
  logic [COEF_W-1:0]          in_coef;
  logic [SAMPLE_W-1:0]        in_sample;

  assign in_action  = s_axis_tuser[0];
  assign in_channel = s_axis_tuser[1];
  assign in_tap     = s_axis_tdata[TAP_W-1:0];
  assign in_coef    = s_axis_tdata[TAP_W+COEF_W-1:TAP_W];
  assign in_sample  = s_axis_tdata[TAP_W+COEF_W+SAMPLE_W-1:TAP_W+COEF_W];

  // Control state
  fir_state_e        state_q, state_d;
  logic [CLRW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [TCNT_W-1:0] tap_count_q;
  logic [SAMPLE_W-1:0] bias_q;
  logic [PW-1:0]     head_q [CHANNELS];
  logic [PW-1:0]     k_q, pos_q;
  logic [NW-1:0]     left_q;
  logic [HW-1:0]     base_q;
  logic              ch_q;
  logic              rd_vld_q, prod_vld_q;
  logic              m_valid_q;
  logic              out_ch_q, out_sat_q;
  logic [SAMPLE_W-1:0] out_data_q;

  // Datapath
  logic signed [COEF_W-1:0]   coef_rdata_q;
  logic signed [SAMPLE_W-1:0] hist_rdata_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]           acc_q;

  // Memories
  logic [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic [SAMPLE_W-1:0] hist_mem [HDEPTH];

  logic                coef_we, hist_we;
  logic [PW-1:0]       coef_waddr, coef_raddr;
  logic [COEF_W-1:0]   coef_wdata;
  logic [HW-1:0]       hist_waddr, hist_raddr;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic                start, rd_issue, out_load;

  // Decode of the incoming word
  logic [CW-1:0]  ch_idx;
  logic           ch_ok;
  logic           tap_ok;
  logic [31:0]    tap_ext;
  logic [PW-1:0]  head_cur, head_nxt;
  logic [HW-1:0]  ch_base;
  logic [31:0]    taps_used;

  assign ch_idx   = CW'(in_channel);
  assign ch_ok    = int'(in_channel) < CHANNELS;
  assign tap_ext  = 32'(in_tap);
  assign tap_ok   = int'(in_tap) < MAX_TAPS;
  assign head_cur = head_q[ch_idx];
  assign head_nxt = (int'(head_cur) == MAX_TAPS - 1) ? '0 : head_cur + 1'b1;
  assign ch_base  = HW'(int'(ch_idx) * MAX_TAPS);

  // Clamp tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count_q == '0) begin
      taps_used = 32'd1;
    end else if (int'(tap_count_q) > MAX_TAPS) begin
      taps_used = 32'(MAX_TAPS);
    end else begin
      taps_used = 32'(tap_count_q);
    end
  end

  // Sequencer: next state and memory controls
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    s_axis_tready = 1'b0;
    coef_we    = 1'b0;
    coef_waddr = '0;
    coef_wdata = '0;
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    start      = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        coef_we    = int'(clr_cnt_q) < MAX_TAPS;
        coef_waddr = clr_cnt_q[PW-1:0];
        hist_we    = 1'b1;
        hist_waddr = clr_cnt_q[HW-1:0];
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (int'(clr_cnt_q) == HDEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_action == ACT_COEF) begin
            coef_we    = tap_ok;
            coef_waddr = tap_ext[PW-1:0];
            coef_wdata = in_coef;
          end else if (ch_ok) begin
            hist_we    = 1'b1;
            hist_waddr = ch_base + HW'(head_cur);
            hist_wdata = in_sample;
            start      = 1'b1;
            state_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rd_issue = 1'b1;
        if (left_q == NW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RST;
      bias_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TAP_COUNT: tap_count_q <= cfg_data_i[TCNT_W-1:0];
        REG_BIAS:      bias_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring heads: advance on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head_q[c] <= '0;
      end
    end else if (start) begin
      head_q[ch_idx] <= head_nxt;
    end
  end

  // Tap walk: coefficient index up, ring position down
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      pos_q      <= '0;
      left_q     <= '0;
      base_q     <= '0;
      ch_q       <= 1'b0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= rd_issue;
      prod_vld_q <= rd_vld_q;
      if (start) begin
        k_q    <= '0;
        pos_q  <= head_cur;
        left_q <= NW'(taps_used);
        base_q <= ch_base;
        ch_q   <= in_channel;
      end else if (rd_issue) begin
        k_q    <= k_q + 1'b1;
        pos_q  <= (pos_q == '0) ? PW'(MAX_TAPS - 1) : pos_q - 1'b1;
        left_q <= left_q - 1'b1;
      end
    end
  end

  assign coef_raddr = k_q;
  assign hist_raddr = base_q + HW'(pos_q);

  // Coefficient memory
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata_q <= coef_mem[coef_raddr];
  end

  // Sample history memory, one ring per channel
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  // Multiply, then accumulate; the bias and the rounding half LSB seed the sum
  always_ff @(posedge clk_i) begin
    prod_q <= coef_rdata_q * hist_rdata_q;
    if (start) begin
      acc_q <= ({{(ACC_W-SAMPLE_W){bias_q[SAMPLE_W-1]}}, bias_q} << FRAC_SHIFT) + ROUND_HALF;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Floor to Q1.23 and saturate
  logic [ACC_W-TOP_LO-1:0] acc_top;
  logic                    acc_fits;
  logic [SAMPLE_W-1:0]     y_sat;

  assign acc_top  = acc_q[ACC_W-1:TOP_LO];
  assign acc_fits = (&acc_top) || !(|acc_top);
  assign y_sat    = acc_fits ? acc_q[TOP_LO:FRAC_SHIFT]
                             : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_sat_q  <= !acc_fits;
      out_data_q <= y_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_sat_q, out_ch_q};

endmodule

/* rtl/mcfir_checker.sv */
module mcfir_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [mcfir_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mcfir_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input logic [mcfir_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

  import mcfir_pkg::*;

  logic s_word;

  assign s_word = s_axis_tvalid && s_axis_tready;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A clipped result sits on one of the rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata == SAT_MAX || m_axis_tdata == SAT_MIN)
    else $error("saturated flag without rail value");

  // A coefficient word produces no result
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_word && s_axis_tuser[0] == ACT_COEF && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after coefficient word");

  // A sample of channel zero starts the tap walk and blocks the input
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_word && s_axis_tuser[0] == ACT_SAMPLE && !s_axis_tuser[1] |=> !s_axis_tready)
    else $error("input still open after sample word");

  // A new result only follows a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared straight from idle");

endmodule

bind multichannel_fir_filter_with_bias mcfir_checker u_mcfir_checker (.*);

/* sim/tb_multichannel_fir_filter_with_bias.sv */
module tb_multichannel_fir_filter_with_bias;
  import mcfir_pkg::*;

  localparam int N_TAPS = 64;
  localparam int N_CH = 2;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = N_TAPS + 12;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER = 150;

  typedef struct packed {
    logic                ch;
    logic [SAMPLE_W-1:0] y;
    logic                sat;
  } fir_result_t;

  // Tracks coefficient and history state and queues the filtered words due
  class filtered_tracker;
    logic signed [COEF_W-1:0]   coefs[N_TAPS];
    logic signed [SAMPLE_W-1:0] history[N_CH][N_TAPS];
    int unsigned                head[N_CH];
    logic [TCNT_W-1:0]          tap_cnt;
    logic signed [SAMPLE_W-1:0] bias_q;
    fir_result_t                filtered_due[$];
    int                         mismatches;

    function new();
      foreach (coefs[k]) coefs[k] = '0;
      foreach (history[c, k]) history[c][k] = '0;
      foreach (head[c]) head[c] = 0;
      tap_cnt = TAP_COUNT_RST;
      bias_q = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
      if (idx == REG_TAP_COUNT) begin
        tap_cnt = val[TCNT_W-1:0];
      end else if (idx == REG_BIAS) begin
        bias_q = val;
      end
    endfunction

    // Update state for an accepted input word and queue its filtered output
    function void take_word(input logic act, input logic ch, input logic [TAP_W-1:0] tap,
                            input logic [COEF_W-1:0] coef, input logic [SAMPLE_W-1:0] smp);
      longint      acc;
      longint      y;
      int unsigned n;
      int unsigned pos;
      fir_result_t r;
      if (act == ACT_COEF) begin
        coefs[tap] = coef;
        return;
      end
      n = (tap_cnt == 0) ? 1 : (tap_cnt > N_TAPS) ? N_TAPS : tap_cnt;
      pos = head[ch];
      history[ch][pos] = smp;
      acc = longint'(bias_q) * 64'sd4194304;
      for (int unsigned k = 0; k < n; k++) begin
        acc += longint'(coefs[k]) * longint'(history[ch][pos]);
        pos = (pos == 0) ? N_TAPS - 1 : pos - 1;
      end
      // round half up, then floor back to Q1.23
      acc += 64'sd2097152;
      y = acc >>> FRAC_SHIFT;
      r.ch = ch;
      r.sat = 1'b0;
      if (y > 64'sd8388607) begin
        y = 64'sd8388607;
        r.sat = 1'b1;
      end else if (y < -64'sd8388608) begin
        y = -64'sd8388608;
        r.sat = 1'b1;
      end
      r.y = y[SAMPLE_W-1:0];
      head[ch] = (head[ch] + 1 >= N_TAPS) ? 0 : head[ch] + 1;
      filtered_due.push_back(r);
    endfunction

    // Compare an output word against the oldest queued result
    function void check_output(input logic ch, input logic [SAMPLE_W-1:0] y, input logic sat);
      fir_result_t e;
      if (filtered_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: ch=%0d y=%h sat=%0b", ch, y, sat);
        return;
      end
      e = filtered_due.pop_front();
      if (e.ch !== ch || e.y !== y || e.sat !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: exp ch=%0d y=%h sat=%0b, got ch=%0d y=%h sat=%0b",
                   e.ch, e.y, e.sat, ch, y, sat);
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SAMPLE_W-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  filtered_tracker fir_state;
  bit              quiet = 1'b0;
  int              results_seen = 0;

  multichannel_fir_filter_with_bias #(
    .MAX_TAPS(N_TAPS),
    .CHANNELS(N_CH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pick a 24-bit value: rails, zero, full range or small magnitude
  function automatic logic [SAMPLE_W-1:0] pick_value();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return '0;
      3, 4: return SAMPLE_W'($urandom);
      default: return {{8{r[15]}}, r};
    endcase
  endfunction

  // Offer one input word, with an occasional idle gap first
  task automatic send_word(input logic act, input logic ch, input logic [TAP_W-1:0] tap,
                           input logic [COEF_W-1:0] coef, input logic [SAMPLE_W-1:0] smp);
    int gap;
    if (!quiet && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, smp, coef, tap};
    s_axis_tuser <= {ch, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fir_state.take_word(act, ch, tap, coef, smp);
  endtask

  task automatic send_random();
    logic act;
    act = ($urandom_range(99) < 75) ? ACT_SAMPLE : ACT_COEF;
    send_word(act, 1'($urandom), TAP_W'($urandom), pick_value(), pick_value());
  endtask

  // Drop valid, wait for every output to drain plus the pipeline depth
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (fir_state.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write tap count then bias back to back
  task automatic apply_setting(input logic [TCNT_W-1:0] taps, input logic [SAMPLE_W-1:0] bias);
    logic [SAMPLE_W-1:0] vals[2];
    logic [CFG_IDX_W-1:0] idxs[2];
    vals[0] = {17'b0, taps};
    vals[1] = bias;
    idxs[0] = REG_TAP_COUNT;
    idxs[1] = REG_BIAS;
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      fir_state.write_reg(idxs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      fir_state.check_output(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
    end
  end

  // Drive output ready: random stalls, one long hold-off to back up the input
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 10);
      @(posedge clk_i);
    end
  end

  initial begin
    #(8 * 2_000_000);
    $display("tb_multichannel_fir_filter_with_bias: FAIL");
    $finish;
  end

  initial begin
    logic [TCNT_W-1:0]   taps;
    logic [SAMPLE_W-1:0] bias;
    fir_state = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one tap, zero coefficients, zero bias
    send_word(ACT_SAMPLE, 1'b0, 6'd63, SAT_MIN, SAT_MAX);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, SAT_MAX, SAT_MIN);
    // Unity coefficient passes the rails through
    send_word(ACT_COEF, 1'b1, 6'd0, 24'h40_0000, SAT_MAX);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, SAT_MAX);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, SAT_MIN);
    // Largest coefficient drives both rails into saturation
    send_word(ACT_COEF, 1'b0, 6'd0, SAT_MAX, '0);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, SAT_MAX);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, SAT_MIN);
    // One-LSB coefficient exposes rounding ties
    send_word(ACT_COEF, 1'b0, 6'd0, 24'h00_0001, '0);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, 24'h20_0000);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, 24'hE0_0000);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, 24'h1F_FFFF);
    // Fill the far taps, then use the full length with the bias at its rails
    send_word(ACT_COEF, 1'b1, 6'd63, SAT_MIN, SAT_MAX);
    send_word(ACT_COEF, 1'b0, 6'd1, 24'h20_0000, '0);
    settle();
    apply_setting(7'd64, SAT_MAX);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, '0);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, SAT_MAX);
    settle();
    apply_setting(7'd0, SAT_MIN);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, 24'h00_1234);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, SAT_MIN);
    settle();
    apply_setting(7'd127, 24'h00_0100);
    send_word(ACT_SAMPLE, 1'b0, 6'd0, '0, SAT_MIN);
    send_word(ACT_SAMPLE, 1'b1, 6'd0, '0, 24'h7F_0000);
    settle();

    // Random phases across tap counts and biases, one phase without idling
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: taps = 7'd64;
        1: taps = 7'd1;
        2: taps = 7'd0;
        3: taps = 7'd127;
        4: taps = 7'd65;
        default: taps = 7'($urandom_range(1, 64));
      endcase
      bias = (p == 1) ? SAT_MIN : (p == 3) ? SAT_MAX : pick_value();
      apply_setting(taps, bias);
      quiet = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      settle();
      quiet = 1'b0;
    end

    if (fir_state.mismatches == 0) begin
      $display("tb_multichannel_fir_filter_with_bias: PASS");
    end else begin
      $display("tb_multichannel_fir_filter_with_bias: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mcfir_pkg.sv
rtl/multichannel_fir_filter_with_bias.sv
rtl/mcfir_checker.sv
sim/tb_multichannel_fir_filter_with_bias.sv
